// File: rtl/core/epoch_seconds_to_calendar_macros.svh
// Assertion helpers shared by the calendar converter RTL.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECAL_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ecal assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ECAL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ecal assertion failed");

`endif

// File: rtl/core/ecal_pkg.sv
`default_nettype none

package ecal_pkg;

    // Time constants in seconds
    localparam logic [31:0] SECS_PER_MIN   = 32'd60;
    localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [31:0] SECS_YEAR      = 32'd31536000;   // 365 days
    localparam logic [31:0] SECS_LEAP_YEAR = 32'd31622400;   // 366 days

    localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
    localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;            // Thursday
    localparam logic [3:0]  LAST_MONTH    = 4'd12;
    localparam logic [11:0] SKIP_LEAP_YEAR = 12'd2100;       // century, not by 400

    // Microcode program counter
    typedef enum logic [2:0] {
        STEP_WAIT,
        STEP_YEAR,
        STEP_MONTH,
        STEP_DAY,
        STEP_HOUR,
        STEP_MIN,
        STEP_EMIT
    } step_t;

    typedef enum logic [1:0] {
        OP_WAIT,   // take a new transaction
        OP_SUB,    // subtract unit while it fits, else jump
        OP_EMIT    // hand the result to the output register
    } op_t;

    typedef enum logic [2:0] {
        UNIT_YEAR,
        UNIT_MONTH,
        UNIT_DAY,
        UNIT_HOUR,
        UNIT_MIN
    } unit_t;

    typedef struct packed {
        op_t   op;
        unit_t unit;
        step_t next;
    } ctrl_t;

    // Program ROM
    function automatic ctrl_t ecal_rom(input step_t step);
        ctrl_t w;
        unique case (step)
            STEP_WAIT:  w = '{op: OP_WAIT, unit: UNIT_YEAR,  next: STEP_YEAR};
            STEP_YEAR:  w = '{op: OP_SUB,  unit: UNIT_YEAR,  next: STEP_MONTH};
            STEP_MONTH: w = '{op: OP_SUB,  unit: UNIT_MONTH, next: STEP_DAY};
            STEP_DAY:   w = '{op: OP_SUB,  unit: UNIT_DAY,   next: STEP_HOUR};
            STEP_HOUR:  w = '{op: OP_SUB,  unit: UNIT_HOUR,  next: STEP_MIN};
            STEP_MIN:   w = '{op: OP_SUB,  unit: UNIT_MIN,   next: STEP_EMIT};
            STEP_EMIT:  w = '{op: OP_EMIT, unit: UNIT_YEAR,  next: STEP_WAIT};
            default:    w = '{op: OP_WAIT, unit: UNIT_YEAR,  next: STEP_WAIT};
        endcase
        return w;
    endfunction

    // Leap rule over 1970..2106: only the year 2100 breaks the divide-by-4 rule
    function automatic logic ecal_is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != SKIP_LEAP_YEAR);
    endfunction

    // Days in a month, 1 = January
    function automatic logic [4:0] ecal_month_days(input logic leap, input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // Month length in seconds; anything else never fits so the loop stops
    function automatic logic [31:0] ecal_days_secs(input logic [4:0] d);
        logic [31:0] s;
        case (d)
            5'd28:   s = 32'd2419200;
            5'd29:   s = 32'd2505600;
            5'd30:   s = 32'd2592000;
            5'd31:   s = 32'd2678400;
            default: s = 32'hFFFF_FFFF;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/epoch_seconds_to_calendar.sv
// Sequence: an input transaction is taken in the wait step; whole years,
//   months, days, hours and minutes are then peeled off by subtraction.
// Flow: one conversion at a time; the subtract loop of the sequencer sets the
//   rate, and the emit step holds while the output register is full and not
//   taken. A finished result may wait in the output register while the next
//   input is taken.
// Reset: synchronous active-low aresetn returns the sequencer to wait and
//   drops m_valid.
`default_nettype none
`include "epoch_seconds_to_calendar_macros.svh"

module epoch_seconds_to_calendar
    import ecal_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_epoch_seconds,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [11:0]      m_year,
    output logic [3:0]       m_month,
    output logic [4:0]       m_day,
    output logic [4:0]       m_hour,
    output logic [5:0]       m_minute,
    output logic [5:0]       m_second,
    output logic [2:0]       m_weekday
);

    step_t       step_reg, step_next;
    logic [31:0] rem_reg, rem_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [2:0]  wd_reg, wd_next;

    logic        out_valid_reg, out_valid_next;
    logic [11:0] out_year_reg, out_year_next;
    logic [3:0]  out_month_reg, out_month_next;
    logic [4:0]  out_day_reg, out_day_next;
    logic [4:0]  out_hour_reg, out_hour_next;
    logic [5:0]  out_min_reg, out_min_next;
    logic [5:0]  out_sec_reg, out_sec_next;
    logic [2:0]  out_wd_reg, out_wd_next;

    ctrl_t       ctrl;
    logic        leap;
    logic [4:0]  mdays;
    logic [31:0] unit_secs;
    logic [1:0]  wd_adv;
    logic        fits;
    logic [31:0] diff;
    logic [3:0]  wd_sum;
    logic [2:0]  wd_step;

    // Control word and unit selection
    always_comb begin
        ctrl  = ecal_rom(step_reg);
        leap  = ecal_is_leap(year_reg);
        mdays = ecal_month_days(leap, month_reg);
        unique case (ctrl.unit)
            UNIT_YEAR: begin
                unit_secs = leap ? SECS_LEAP_YEAR : SECS_YEAR;
                wd_adv    = leap ? 2'd2 : 2'd1;
            end
            UNIT_MONTH: begin
                unit_secs = ecal_days_secs(mdays);
                wd_adv    = 2'(mdays - 5'd28);
            end
            UNIT_DAY: begin
                unit_secs = SECS_PER_DAY;
                wd_adv    = 2'd1;
            end
            UNIT_HOUR: begin
                unit_secs = SECS_PER_HOUR;
                wd_adv    = 2'd0;
            end
            default: begin
                unit_secs = SECS_PER_MIN;
                wd_adv    = 2'd0;
            end
        endcase
        fits    = (rem_reg >= unit_secs);
        diff    = rem_reg - unit_secs;
        wd_sum  = {1'b0, wd_reg} + {2'b00, wd_adv};
        wd_step = (wd_sum > 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
    end

    assign s_ready = (ctrl.op == OP_WAIT);

    // Sequencer and datapath next state
    always_comb begin
        step_next      = step_reg;
        rem_next       = rem_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        hour_next      = hour_reg;
        min_next       = min_reg;
        wd_next        = wd_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_year_next  = out_year_reg;
        out_month_next = out_month_reg;
        out_day_next   = out_day_reg;
        out_hour_next  = out_hour_reg;
        out_min_next   = out_min_reg;
        out_sec_next   = out_sec_reg;
        out_wd_next    = out_wd_reg;

        unique case (ctrl.op)
            OP_WAIT: begin
                if (s_valid) begin
                    rem_next   = s_epoch_seconds;
                    year_next  = EPOCH_YEAR;
                    month_next = 4'd1;
                    day_next   = 5'd1;
                    hour_next  = 5'd0;
                    min_next   = 6'd0;
                    wd_next    = EPOCH_WEEKDAY;
                    step_next  = ctrl.next;
                end
            end
            OP_SUB: begin
                if (fits) begin
                    rem_next = diff;
                    wd_next  = wd_step;
                    unique case (ctrl.unit)
                        UNIT_YEAR:  year_next  = year_reg + 12'd1;
                        UNIT_MONTH: month_next = month_reg + 4'd1;
                        UNIT_DAY:   day_next   = day_reg + 5'd1;
                        UNIT_HOUR:  hour_next  = hour_reg + 5'd1;
                        default:    min_next   = min_reg + 6'd1;
                    endcase
                end else begin
                    step_next = ctrl.next;
                end
            end
            default: begin
                // emit once the output register is free
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_year_next  = year_reg;
                    out_month_next = month_reg;
                    out_day_next   = day_reg;
                    out_hour_next  = hour_reg;
                    out_min_next   = min_reg;
                    out_sec_next   = rem_reg[5:0];
                    out_wd_next    = wd_reg;
                    step_next      = ctrl.next;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_WAIT;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rem_reg       <= rem_next;
        year_reg      <= year_next;
        month_reg     <= month_next;
        day_reg       <= day_next;
        hour_reg      <= hour_next;
        min_reg       <= min_next;
        wd_reg        <= wd_next;
        out_year_reg  <= out_year_next;
        out_month_reg <= out_month_next;
        out_day_reg   <= out_day_next;
        out_hour_reg  <= out_hour_next;
        out_min_reg   <= out_min_next;
        out_sec_reg   <= out_sec_next;
        out_wd_reg    <= out_wd_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_year    = out_year_reg;
    assign m_month   = out_month_reg;
    assign m_day     = out_day_reg;
    assign m_hour    = out_hour_reg;
    assign m_minute  = out_min_reg;
    assign m_second  = out_sec_reg;
    assign m_weekday = out_wd_reg;

    // Checks
    `ECAL_ASSERT_NEXT(a_start_year, aclk, aresetn, s_valid && s_ready, step_reg == STEP_YEAR)
    `ECAL_ASSERT_SAME(a_month_bound, aclk, aresetn, step_reg == STEP_MONTH, month_reg <= LAST_MONTH)
    `ECAL_ASSERT_SAME(a_sec_left, aclk, aresetn, step_reg == STEP_EMIT, rem_reg < SECS_PER_MIN)
    `ECAL_ASSERT_SAME(a_out_nonzero, aclk, aresetn, m_valid, (m_month != 4'd0) && (m_day != 5'd0) && (m_weekday != 3'd0))

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Calendar arithmetic, kept apart from the design's package
    localparam int unsigned MIN_SECS  = 60;
    localparam int unsigned HOUR_SECS = 3600;
    localparam int unsigned DAY_SECS  = 86400;
    localparam int unsigned FIRST_YEAR = 1970;
    localparam int unsigned NORMAL_MONTH_DAYS [12] =
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned LAST_WHOLE_DAY = 49709;  // last day that fits a full 86400 s

    localparam int IDLE_PERCENT = 13;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } calendar_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_epoch_seconds = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [11:0] m_year;
    logic [3:0]  m_month;
    logic [4:0]  m_day;
    logic [4:0]  m_hour;
    logic [5:0]  m_minute;
    logic [5:0]  m_second;
    logic [2:0]  m_weekday;

    calendar_t expected_dates[$];
    int        failures = 0;
    int        quiet_cycles = 0;
    bit        idling_on = 1'b1;

    epoch_seconds_to_calendar dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day           (m_day),
        .m_hour          (m_hour),
        .m_minute        (m_minute),
        .m_second        (m_second),
        .m_weekday       (m_weekday)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Gregorian rule: every 4th year, except centuries not divisible by 400
    function automatic bit is_leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // Seconds since the epoch to date, time of day and weekday
    function automatic calendar_t to_calendar(input logic [31:0] secs);
        calendar_t   c;
        int unsigned left;
        int unsigned whole_days;
        int unsigned yr;
        int unsigned mo;
        int unsigned mlen;
        bit          leap;
        left       = secs;
        whole_days = secs / DAY_SECS;
        yr         = FIRST_YEAR;
        while (left >= (is_leap_year(yr) ? 366 : 365) * DAY_SECS) begin
            left -= (is_leap_year(yr) ? 366 : 365) * DAY_SECS;
            yr++;
        end
        leap = is_leap_year(yr);
        mo   = 0;
        while (mo < 12) begin
            mlen = NORMAL_MONTH_DAYS[mo] + ((mo == 1 && leap) ? 1 : 0);
            if (left < mlen * DAY_SECS) break;
            left -= mlen * DAY_SECS;
            mo++;
        end
        c.year    = yr[11:0];
        c.month   = 4'(mo + 1);
        c.day     = 5'(left / DAY_SECS + 1);
        left      = left % DAY_SECS;
        c.hour    = 5'(left / HOUR_SECS);
        left      = left % HOUR_SECS;
        c.minute  = 6'(left / MIN_SECS);
        c.second  = 6'(left % MIN_SECS);
        c.weekday = 3'((whole_days + 3) % 7 + 1);
        return c;
    endfunction

    // One input transaction; called and returns just after a falling edge
    task automatic send_seconds(input logic [31:0] secs);
        while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid         <= 1'b0;
            s_epoch_seconds <= $urandom;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_epoch_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
        expected_dates.push_back(to_calendar(secs));
        @(negedge aclk);
    endtask

    // Extremes, leap handling, the 2^31 boundary and bit patterns
    task automatic test_directed();
        send_seconds(32'd0);             // 1970-01-01 00:00:00, Thursday
        send_seconds(32'd59);
        send_seconds(32'd60);
        send_seconds(32'd3599);
        send_seconds(32'd3600);
        send_seconds(32'd86399);
        send_seconds(32'd86400);
        send_seconds(32'd31535999);      // last second of 1970
        send_seconds(32'd31536000);      // first second of 1971
        send_seconds(32'd68169600);      // 1972-02-29, leap day
        send_seconds(32'd68256000);      // 1972-03-01
        send_seconds(32'd951782400);     // 2000-02-29, century divisible by 400
        send_seconds(32'd978307199);     // 2000-12-31 23:59:59
        send_seconds(32'd2147483647);    // last signed count
        send_seconds(32'd2147483648);    // first count with the top bit set
        send_seconds(32'd4107542399);    // 2100-02-28 23:59:59, no leap day
        send_seconds(32'd4107542400);    // 2100-03-01
        send_seconds(32'hFFFF_FFFF);     // 2106-02-07 06:28:15, Sunday
        send_seconds(32'h5555_5555);
        send_seconds(32'hAAAA_AAAA);
        send_seconds(32'hFFFF_0000);
        send_seconds(32'h0000_FFFF);
    endtask

    // Uniform counts over the full 32-bit range
    task automatic test_random_counts(input int count);
        repeat (count) send_seconds($urandom);
    endtask

    // Counts a few seconds either side of midnight, so month and year rollovers are hit
    task automatic test_day_edges(input int count);
        int unsigned d;
        int unsigned off;
        repeat (count) begin
            d   = $urandom_range(LAST_WHOLE_DAY);
            off = ($urandom_range(1) == 0) ? $urandom_range(2)
                                           : DAY_SECS - 1 - $urandom_range(2);
            send_seconds(d * DAY_SECS + off);
        end
    endtask

    // Back-to-back transactions with both sides always willing
    task automatic test_back_to_back(input int count);
        idling_on = 1'b0;
        repeat (count) send_seconds($urandom);
        idling_on = 1'b1;
    endtask

    // Result side back-pressure
    always @(negedge aclk) begin
        m_ready <= idling_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
    end

    task automatic report_field(input string name, input logic [11:0] want,
                                input logic [11:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : check_results
        calendar_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_dates.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d-%0d-%0d",
                         $time, m_year, m_month, m_day);
                failures++;
            end else begin
                want = expected_dates.pop_front();
                report_field("year", want.year, m_year);
                report_field("month", 12'(want.month), 12'(m_month));
                report_field("day", 12'(want.day), 12'(m_day));
                report_field("hour", 12'(want.hour), 12'(m_hour));
                report_field("minute", 12'(want.minute), 12'(m_minute));
                report_field("second", 12'(want.second), 12'(m_second));
                report_field("weekday", 12'(want.weekday), 12'(m_weekday));
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_counts(900);
        test_day_edges(500);
        test_back_to_back(330);
        s_valid <= 1'b0;

        // Drain outstanding results, then let the sequencer settle
        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
